// ===== hw/rtl/sfpa_pkg.sv =====
// Shared types and constants for the saturating fixed-point ALU.
`default_nettype none

package sfpa_pkg;

  localparam int DATA_BITS  = 32;                 // datapath width of operands and results
  localparam int PROD_BITS  = 2 * DATA_BITS;      // full product width
  localparam int TB_BITS    = 6;                  // total_bits register width
  localparam int FB_BITS    = 5;                  // frac_bits register width
  localparam int SHIFT_BITS = $clog2(DATA_BITS);  // width of (width - 1)
  localparam int CFG_IDX_BITS  = 1;
  localparam int CFG_DATA_BITS = 6;

  // tdata layout of a result word, from the lowest bit up
  localparam int OUT_LESS_BIT    = DATA_BITS;
  localparam int OUT_EQUAL_BIT   = DATA_BITS + 1;
  localparam int OUT_GREATER_BIT = DATA_BITS + 2;
  localparam int OUT_TDATA_BITS  = ((DATA_BITS + 3 + 7) / 8) * 8;  // result, flags, whole bytes
  localparam int IN_TDATA_BITS   = 2 * DATA_BITS;
  localparam int IN_TUSER_BITS   = 2;

  // reset values of the format registers
  localparam logic [TB_BITS-1:0] TOTAL_BITS_RST = 6'd16;
  localparam logic [FB_BITS-1:0] FRAC_BITS_RST  = 5'd8;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_TOTAL_BITS = 1'b0,
    CFG_FRAC_BITS  = 1'b1
  } cfg_idx_t;

  typedef enum logic [IN_TUSER_BITS-1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_CMP = 2'd3
  } op_t;

endpackage

`default_nettype wire

// ===== hw/rtl/saturating_fixed_point_alu_unit.sv =====
// Top level: four-stage pipelined saturating fixed-point ALU.
//
// Input channel (s_*): one word per operation. s_tdata carries operand_a in
// the low 32 bits and operand_b above it; s_tuser carries the opcode
// (0 add, 1 subtract, 2 multiply, 3 compare). A word is taken on a clock edge
// with s_tvalid and s_tready both high.
// Output channel (m_*): one word per input word, in order. m_tdata carries the
// saturated result in bits 31:0, then the less, equal and greater flags.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 total_bits,
// 1 frac_bits). Write only while no operation is in flight.
// Four register stages (capture, multiply/add/compare, round and shift,
// saturate); the capture stage loads on the handshake edge itself.
// Throughput: one word per cycle while m_tready is high; the 32x32
// multiplier in stage 2 is the deepest logic and sets the clock rate.
// Each stage holds a valid bit and advances when its successor is empty or
// moving, so bubbles collapse and input is taken while a result waits.
// When m_tready is low the pipe fills up; s_tready drops only once all four
// stages hold words. Nothing is dropped or repeated across a stall.
// Reset (rst, synchronous) clears all valid bits and restores total_bits 16,
// frac_bits 8.
`default_nettype none

module saturating_fixed_point_alu_unit (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  input  wire logic [sfpa_pkg::IN_TDATA_BITS-1:0]  s_tdata,   // operand_a, operand_b
  input  wire logic [sfpa_pkg::IN_TUSER_BITS-1:0]  s_tuser,   // opcode
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  output logic [sfpa_pkg::OUT_TDATA_BITS-1:0]      m_tdata,   // result_value, is_less,
                                                              // is_equal, is_greater, pad
  input  wire logic                                cfg_we,
  input  wire logic [sfpa_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  wire logic [sfpa_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  localparam int DB = sfpa_pkg::DATA_BITS;
  localparam int PB = sfpa_pkg::PROD_BITS;

  // format registers
  logic [sfpa_pkg::TB_BITS-1:0]    total_bits;
  logic [sfpa_pkg::FB_BITS-1:0]    frac_bits;
  logic [sfpa_pkg::SHIFT_BITS-1:0] width_m1;
  logic signed [DB-1:0]            lim_hi;     // 2^(w-1)-1, registered from format

  // stage valids and per-stage advance
  logic v1, v2, v3, v4;
  logic adv1, adv2, adv3, adv4;

  // stage 1: capture
  sfpa_pkg::op_t        op1;
  logic signed [DB-1:0] a1, b1;

  // stage 2: multiply, add/subtract, compare
  sfpa_pkg::op_t        op2;
  logic signed [PB-1:0] prod2;
  logic signed [DB:0]   sum2;
  logic [2:0]           flags2;   // {greater, equal, less}

  // stage 3: round and shift, merge paths
  sfpa_pkg::op_t        op3;
  logic signed [PB-1:0] val3;
  logic [2:0]           flags3;
  logic signed [PB-1:0] rnd;
  logic signed [PB-1:0] shifted;

  // stage 4: saturate into output register
  logic signed [DB-1:0] res4;
  logic [2:0]           flags4;
  logic signed [PB-1:0] hi_ext, lo_ext;
  logic signed [DB-1:0] sat;

  // Advance chain: a stage may load when it is empty or its word moves on.
  assign adv4 = !v4 || m_tready;
  assign adv3 = !v3 || adv4;
  assign adv2 = !v2 || adv3;
  assign adv1 = !v1 || adv2;
  assign s_tready = adv1;

  // Effective width clamped to 2..DATA_BITS, kept as width - 1.
  always_comb begin
    priority if (total_bits < sfpa_pkg::TB_BITS'(2)) begin
      width_m1 = sfpa_pkg::SHIFT_BITS'(1);
    end else if (total_bits > sfpa_pkg::TB_BITS'(DB)) begin
      width_m1 = sfpa_pkg::SHIFT_BITS'(DB - 1);
    end else begin
      width_m1 = sfpa_pkg::SHIFT_BITS'(total_bits - sfpa_pkg::TB_BITS'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total_bits <= sfpa_pkg::TOTAL_BITS_RST;
      frac_bits  <= sfpa_pkg::FRAC_BITS_RST;
    end else if (cfg_we) begin
      unique case (sfpa_pkg::cfg_idx_t'(cfg_index))
        sfpa_pkg::CFG_TOTAL_BITS: total_bits <= cfg_data[sfpa_pkg::TB_BITS-1:0];
        sfpa_pkg::CFG_FRAC_BITS:  frac_bits  <= cfg_data[sfpa_pkg::FB_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Limit follows format; user keeps config static while words are in flight; unenforced.
  always_ff @(posedge clk) begin
    lim_hi <= (DB'(1) << width_m1) - DB'(1);
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (adv1) v1 <= s_tvalid;
      if (adv2) v2 <= v1;
      if (adv3) v3 <= v2;
      if (adv4) v4 <= v3;
    end
  end

  // Stage 1.
  always_ff @(posedge clk) begin
    if (adv1) begin
      op1 <= sfpa_pkg::op_t'(s_tuser);
      a1  <= s_tdata[DB-1:0];
      b1  <= s_tdata[2*DB-1:DB];
    end
  end

  // Stage 2.
  always_ff @(posedge clk) begin
    if (adv2) begin
      op2   <= op1;
      prod2 <= PB'(a1) * PB'(b1);
      if (op1 == sfpa_pkg::OP_SUB) begin
        sum2 <= (DB+1)'(a1) - (DB+1)'(b1);
      end else begin
        sum2 <= (DB+1)'(a1) + (DB+1)'(b1);
      end
      flags2 <= {a1 > b1, a1 == b1, a1 < b1};
    end
  end

  // Rounding: add half an LSB of the kept part, then floor shift.
  always_comb begin
    if (frac_bits == '0) begin
      rnd = '0;
    end else begin
      rnd = PB'(1) <<< (frac_bits - sfpa_pkg::FB_BITS'(1));
    end
    shifted = (prod2 + rnd) >>> frac_bits;
  end

  // Stage 3.
  always_ff @(posedge clk) begin
    if (adv3) begin
      op3 <= op2;
      unique case (op2)
        sfpa_pkg::OP_ADD, sfpa_pkg::OP_SUB: val3 <= PB'(sum2);
        sfpa_pkg::OP_MUL:                   val3 <= shifted;
        sfpa_pkg::OP_CMP:                   val3 <= '0;
        default:                            val3 <= '0;
      endcase
      flags3 <= (op2 == sfpa_pkg::OP_CMP) ? flags2 : 3'b000;
    end
  end

  // Saturate to [-2^(w-1), 2^(w-1)-1].
  always_comb begin
    hi_ext = PB'(lim_hi);
    lo_ext = ~hi_ext;
    priority if (val3 > hi_ext) begin
      sat = lim_hi;
    end else if (val3 < lo_ext) begin
      sat = ~lim_hi;
    end else begin
      sat = val3[DB-1:0];
    end
  end

  // Stage 4: output register.
  always_ff @(posedge clk) begin
    if (adv4) begin
      res4   <= (op3 == sfpa_pkg::OP_CMP) ? '0 : sat;
      flags4 <= flags3;
    end
  end

  assign m_tvalid = v4;
  assign m_tdata  = {(sfpa_pkg::OUT_TDATA_BITS - DB - 3)'(0), flags4, res4};

endmodule

`default_nettype wire

// ===== hw/rtl/sfpa_checker.sv =====
// Port-level checker for the fixed-point ALU, bound to the top level.
`default_nettype none

module sfpa_checker (
  input wire logic                                clk,
  input wire logic                                rst,
  input wire logic                                s_tready,
  input wire logic                                m_tvalid,
  input wire logic                                m_tready,
  input wire logic [sfpa_pkg::OUT_TDATA_BITS-1:0] m_tdata
);

  logic [2:0] flags;
  assign flags = {m_tdata[sfpa_pkg::OUT_GREATER_BIT], m_tdata[sfpa_pkg::OUT_EQUAL_BIT],
                  m_tdata[sfpa_pkg::OUT_LESS_BIT]};

  // stalled result word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result word changed under stall");

  // compare reports at most one relation
  a_flags: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> $onehot0(flags))
    else $error("more than one compare flag set");

  // a compare word carries a zero result value
  a_cmp_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (flags != 3'b000) |-> m_tdata[sfpa_pkg::DATA_BITS-1:0] == '0)
    else $error("compare word with nonzero result");

  // pipe is empty right after reset
  a_rst: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("result valid right after reset");

  // an empty output stage never blocks input
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled while output empty");

endmodule

bind saturating_fixed_point_alu_unit sfpa_checker u_sfpa_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire
